[hw/rtl/ttrq_pkg.sv]
// ----------------------------------------------------------------------------
// ttrq_pkg
// Shared types and constants of the timed task release queue.
// ----------------------------------------------------------------------------
package ttrq_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int TASK_BITS_DEF = 6;
  localparam int MAX_RESULTS   = 32;
  localparam int TIME_W        = 16;

  localparam logic [TIME_W-1:0] TPU_RESET = 16'd100;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    OC_NONE   = 2'd0,
    OC_START  = 2'd1,
    OC_QUEUED = 2'd2,
    OC_DROP   = 2'd3
  } outcome_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic add;
    logic tick;
    logic pop;
    logic none;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic rel;
    logic more;
  } dp_status_t;

endpackage

[hw/rtl/ttrq_if.sv]
// ----------------------------------------------------------------------------
// ttrq channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttrq_in_if #(
  parameter int TASK_BITS = ttrq_pkg::TASK_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  ttrq_pkg::cmd_code_t           command;
  logic [TASK_BITS-1:0]          task_id;
  logic [ttrq_pkg::TIME_W-1:0]   arrival_time;

  modport source (output valid, command, task_id, arrival_time, input ready);
  modport sink   (input valid, command, task_id, arrival_time, output ready);
endinterface

interface ttrq_out_if #(
  parameter int TASK_BITS = ttrq_pkg::TASK_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  ttrq_pkg::outcome_t   outcome;
  logic [TASK_BITS-1:0] started_task;
  logic                 last;

  modport source (output valid, outcome, started_task, last, input ready);
  modport sink   (input valid, outcome, started_task, last, output ready);
endinterface

[hw/rtl/timed_task_release_queue.sv]
// ----------------------------------------------------------------------------
// timed_task_release_queue
// Time-sorted task queue that starts tasks when their arrival unit comes due.
// ----------------------------------------------------------------------------
// An add request gives one result: started at once when its arrival equals the
// current time unit, queued into the sorted cell chain (equal arrivals keep
// request order), or dropped when DEPTH tasks are held. A tick gives one empty
// result if nothing is released, else n results for n tasks released at a unit
// boundary (n at most 32), as the chain shifts out one head task per cycle
// while the result register is free; each request's last result carries last.
// Results sit in an output register, so a stalled result holds off the next
// request only while it waits. The user writes ticks_per_unit through cfg_we /
// cfg_wdata only while idle (the block does not enforce it); zero acts as one.
module timed_task_release_queue #(
  parameter int DEPTH     = ttrq_pkg::DEPTH_DEF,
  parameter int TASK_BITS = ttrq_pkg::TASK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ttrq_pkg::TIME_W-1:0] cfg_wdata,
  ttrq_in_if.sink                     in_ch,
  ttrq_out_if.source                  out_ch
);

  ttrq_pkg::dp_cmd_t    cmd;
  ttrq_pkg::dp_status_t status;

  ttrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ttrq_datapath #(
    .DEPTH     (DEPTH),
    .TASK_BITS (TASK_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .in_task_id  (in_ch.task_id),
    .in_arrival  (in_ch.arrival_time),
    .out_ready   (out_ch.ready),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_outcome (out_ch.outcome),
    .out_task    (out_ch.started_task),
    .out_last    (out_ch.last)
  );

  // a tick request blocks the input while its releases are scanned
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.command == ttrq_pkg::CMD_TICK |=> !in_ch.ready)
    else $error("input ready right after a tick request");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add, cmd.tick, cmd.pop, cmd.none}))
    else $error("more than one datapath command");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> status.rel && status.out_free)
    else $error("release issued without a due head task");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.outcome == ttrq_pkg::OC_NONE |-> out_ch.last)
    else $error("empty result not marked last");

endmodule

[hw/rtl/ttrq_ctrl.sv]
// ----------------------------------------------------------------------------
// ttrq_ctrl
// Sequencer: takes requests and steps the release scan one task per cycle while the result register is free.
// ----------------------------------------------------------------------------
module ttrq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ttrq_pkg::cmd_code_t  in_command,
  output logic                 in_ready,
  input  ttrq_pkg::dp_status_t status,
  output ttrq_pkg::dp_cmd_t    cmd
);

  ttrq_pkg::state_t state_r;
  ttrq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttrq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttrq_pkg::S_IDLE: begin
        if (in_valid && status.out_free && in_command == ttrq_pkg::CMD_TICK) begin
          state_nxt = ttrq_pkg::S_SCAN;
        end
      end
      ttrq_pkg::S_SCAN: begin
        // leave after the last release, or after the empty result
        if (status.out_free && !(status.rel && status.more)) begin
          state_nxt = ttrq_pkg::S_IDLE;
        end
      end
      default: state_nxt = ttrq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ttrq_pkg::S_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.add  = (in_command == ttrq_pkg::CMD_ADD);
          cmd.tick = (in_command == ttrq_pkg::CMD_TICK);
        end
      end
      ttrq_pkg::S_SCAN: begin
        if (status.out_free) begin
          cmd.pop  = status.rel;
          cmd.none = !status.rel;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/ttrq_datapath.sv]
// ----------------------------------------------------------------------------
// ttrq_datapath
// Sorted cell chain, tick counters, tick period register and result register.
// ----------------------------------------------------------------------------
module ttrq_datapath #(
  parameter int DEPTH     = ttrq_pkg::DEPTH_DEF,
  parameter int TASK_BITS = ttrq_pkg::TASK_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ttrq_pkg::TIME_W-1:0] cfg_wdata,
  input  ttrq_pkg::dp_cmd_t           cmd,
  input  logic [TASK_BITS-1:0]        in_task_id,
  input  logic [ttrq_pkg::TIME_W-1:0] in_arrival,
  input  logic                        out_ready,
  output ttrq_pkg::dp_status_t        status,
  output logic                        out_valid,
  output ttrq_pkg::outcome_t          out_outcome,
  output logic [TASK_BITS-1:0]        out_task,
  output logic                        out_last
);

  localparam int TW = ttrq_pkg::TIME_W;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(ttrq_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [NW-1:0] MAX_N    = NW'(ttrq_pkg::MAX_RESULTS);
  localparam logic [NW-1:0] MAX_N_M1 = NW'(ttrq_pkg::MAX_RESULTS - 1);

  logic [TASK_BITS-1:0] cell_task_r [DEPTH];
  logic [TW-1:0]        cell_arr_r  [DEPTH];
  logic [CW-1:0]        count_r;
  logic [TW-1:0]        tpu_r;
  logic [TW-1:0]        sub_r;
  logic [TW-1:0]        tu_r;
  logic                 bnd_r;
  logic [NW-1:0]        n_r;

  logic                 out_valid_r;
  ttrq_pkg::outcome_t   out_outcome_r;
  logic [TASK_BITS-1:0] out_task_r;
  logic                 out_last_r;

  logic [DEPTH-1:0] place;
  logic             add_start;
  logic             add_full;
  logic             add_ins;
  logic [TW-1:0]    tpu_eff;
  logic [TW:0]      sub_inc;
  logic             wrap;
  logic             load;

  // cells past the fill count count as later than any arrival
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      place[i] = (CW'(i) >= count_r) || (cell_arr_r[i] > in_arrival);
    end
  end

  assign add_start = (in_arrival == tu_r);
  assign add_full  = (count_r == FULL_CNT);
  assign add_ins   = !add_start && !add_full;

  assign tpu_eff = (tpu_r == '0) ? TW'(1) : tpu_r;
  assign sub_inc = {1'b0, sub_r} + (TW+1)'(1);
  assign wrap    = (sub_inc >= {1'b0, tpu_eff});

  assign status.out_free = !out_valid_r || out_ready;
  assign status.rel      = bnd_r && (count_r != '0) && (n_r < MAX_N) && (cell_arr_r[0] <= tu_r);
  assign status.more     = (count_r > CW'(1)) && (n_r < MAX_N_M1) && (cell_arr_r[1] <= tu_r);

  assign load = cmd.add || cmd.pop || cmd.none;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.add && add_ins && place[g]) begin
        if (g > 0 && place[(g > 0) ? g - 1 : 0]) begin
          cell_task_r[g] <= cell_task_r[(g > 0) ? g - 1 : 0];
          cell_arr_r[g]  <= cell_arr_r[(g > 0) ? g - 1 : 0];
        end else begin
          cell_task_r[g] <= in_task_id;
          cell_arr_r[g]  <= in_arrival;
        end
      end else if (cmd.pop && g < DEPTH - 1) begin
        cell_task_r[g] <= cell_task_r[(g < DEPTH - 1) ? g + 1 : g];
        cell_arr_r[g]  <= cell_arr_r[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tpu_r       <= ttrq_pkg::TPU_RESET;
      sub_r       <= '0;
      tu_r        <= '0;
      bnd_r       <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpu_r <= cfg_wdata;
      end
      if (cmd.add && add_ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.tick) begin
        bnd_r <= wrap;
        n_r   <= '0;
        if (wrap) begin
          sub_r <= '0;
          tu_r  <= tu_r + TW'(1);
        end else begin
          sub_r <= sub_inc[TW-1:0];
        end
      end else if (cmd.pop) begin
        n_r <= n_r + NW'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      out_task_r <= in_task_id;
      out_last_r <= 1'b1;
      if (add_start) begin
        out_outcome_r <= ttrq_pkg::OC_START;
      end else if (add_full) begin
        out_outcome_r <= ttrq_pkg::OC_DROP;
      end else begin
        out_outcome_r <= ttrq_pkg::OC_QUEUED;
      end
    end else if (cmd.pop) begin
      out_outcome_r <= ttrq_pkg::OC_START;
      out_task_r    <= cell_task_r[0];
      out_last_r    <= !status.more;
    end else if (cmd.none) begin
      out_outcome_r <= ttrq_pkg::OC_NONE;
      out_task_r    <= '0;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_task    = out_task_r;
  assign out_last    = out_last_r;

endmodule
